[src/ahd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_pkg
// shared constants, register indexes and stage payload types of the
// adaptive hysteresis detector
// ----------------------------------------------------------------------------
package ahd_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 12;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 4;
    localparam int THR_W    = 13;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;

    // block and window lengths
    localparam int AVG_COUNT  = 4;
    localparam int WINDOW_LEN = 6;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // reset values of the registers
    localparam logic [LEVEL_W-1:0] BASE_HIGH_RST  = 12'd40;
    localparam logic [LEVEL_W-1:0] BASE_LOW_RST   = 12'd20;
    localparam logic [THR_W-1:0]   DRIVE_THR_RST  = 13'd4400;
    localparam logic [LEVEL_W-1:0] WIN_MIN_RST    = 12'd4095;

    // register indexes
    localparam logic [IDX_W-1:0] REG_BASE_HIGH = 2'd0;
    localparam logic [IDX_W-1:0] REG_BASE_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_DRIVE_THR = 2'd2;

    // payload after the averaging stage
    typedef struct packed {
        logic               switch_level;
        logic               drive_high;
        logic [LEVEL_W-1:0] level;
    } t_avg_out;

    // payload after the window stage
    typedef struct packed {
        logic               switch_level;
        logic               drive_high;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] spread;
    } t_win_out;

    // payload of one result
    typedef struct packed {
        logic               out_level;
        logic               detect_flag;
        logic               drive_high;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] spread;
    } t_result;

endpackage

[src/adaptive_hysteresis_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_hysteresis_detector_unit
// two-channel averaging level detector with noise-adaptive hysteresis
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request per acquisition: two 12-bit samples and the
//   polarity switch level. m_axis returns exactly one result per request,
//   in order: out level, detect flag, next drive choice, held level, spread.
//   the config port writes base_high, base_low and drive_threshold by index
//   (0, 1, 2); other indexes are ignored. write only while the block is idle.
// pipeline and throughput
//   three register stages (averaging, window, hysteresis): an accepted
//   request passes from the averaging register through the window register
//   into the output register of the hysteresis stage, where m_axis takes it.
//   one request per cycle is sustained while m_axis_tready stays high; each
//   stage updates its state in one combinational step per accepted request.
// reset
//   synchronous active-low reset empties the pipe, clears the sums, window,
//   spread and detect flag, and loads the register defaults 40, 20, 4400.
// stall
//   when m_axis_tready is low the result holds in the output register; the
//   earlier stages keep filling until each holds an item, then s_axis_tready
//   drops. no request is lost or repeated.
// ----------------------------------------------------------------------------
module adaptive_hysteresis_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] sample_a, [23:12] sample_b, [24] switch_level, rest zero
    input  logic [ahd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] out_level, [1] detect_flag, [2] drive_high, [14:3] level,
    // [26:15] spread, rest zero
    output logic [ahd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // register writes
    input  logic                                i_cfg_wr_en,
    input  logic [ahd_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [ahd_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import ahd_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0] r_base_high;
    logic [LEVEL_W-1:0] r_base_low;
    logic [THR_W-1:0]   r_drive_thr;

    // stage links
    logic       avg_valid, avg_ready;
    t_avg_out   avg_data;
    logic       win_valid, win_ready;
    t_win_out   win_data;
    t_result    res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_high <= BASE_HIGH_RST;
            r_base_low  <= BASE_LOW_RST;
            r_drive_thr <= DRIVE_THR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BASE_HIGH: r_base_high <= i_cfg_wdata[LEVEL_W-1:0];
                REG_BASE_LOW:  r_base_low  <= i_cfg_wdata[LEVEL_W-1:0];
                REG_DRIVE_THR: r_drive_thr <= i_cfg_wdata;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // block averaging and drive choice
    ahd_avg u_avg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_sample_a     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_sample_b     (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_switch_level (s_axis_tdata[2*SAMPLE_W]),
        .i_drive_thr    (r_drive_thr),
        .o_valid        (avg_valid),
        .i_ready        (avg_ready),
        .o_data         (avg_data)
    );

    // spread over the level window
    ahd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (avg_valid),
        .o_ready (avg_ready),
        .i_data  (avg_data),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_data  (win_data)
    );

    // hysteresis flag, this stage owns the output register
    ahd_hyst u_hyst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (win_valid),
        .o_ready     (win_ready),
        .i_data      (win_data),
        .i_base_high (r_base_high),
        .i_base_low  (r_base_low),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (res_data)
    );

    assign m_axis_tdata = {
        {(OUT_TDATA_W - 3 - 2*LEVEL_W){1'b0}},
        res_data.spread,
        res_data.level,
        res_data.drive_high,
        res_data.detect_flag,
        res_data.out_level
    };

endmodule

[src/ahd_avg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_avg
// block averaging of both channels and pulse choice, first pipeline stage
// ----------------------------------------------------------------------------
module ahd_avg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ahd_pkg::SAMPLE_W-1:0]    i_sample_a,
    input  logic [ahd_pkg::SAMPLE_W-1:0]    i_sample_b,
    input  logic                            i_switch_level,
    input  logic [ahd_pkg::THR_W-1:0]       i_drive_thr,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ahd_pkg::t_avg_out               o_data
);
    import ahd_pkg::*;

    logic                r_valid;
    t_avg_out            r_data;
    logic [SUM_W-1:0]    r_sum_a, r_sum_b;
    logic [CNT_W-1:0]    r_cnt;
    logic [LEVEL_W-1:0]  r_level;

    logic [SUM_W-1:0]    n_sum_a, n_sum_b;
    logic [CNT_W-1:0]    n_cnt;
    logic [LEVEL_W-1:0]  n_level;
    logic [SUM_W-1:0]    add_a, add_b, av_a, av_b;
    logic [CNT_W-1:0]    cnt_inc;
    logic [THR_W-1:0]    pair_sum;
    logic                block_full;
    logic                load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        add_a      = r_sum_a + SUM_W'(i_sample_a);
        add_b      = r_sum_b + SUM_W'(i_sample_b);
        cnt_inc    = r_cnt + 1'b1;
        // count wraps to zero when the block is as long as the counter range
        block_full = (cnt_inc == '0) || ({1'b0, cnt_inc} >= (CNT_W+1)'(AVG_COUNT));
        av_a       = add_a / SUM_W'(AVG_COUNT);
        av_b       = add_b / SUM_W'(AVG_COUNT);
        pair_sum   = THR_W'(i_sample_a) + THR_W'(i_sample_b);
        n_sum_a    = add_a;
        n_sum_b    = add_b;
        n_cnt      = cnt_inc;
        n_level    = r_level;
        if (block_full) begin
            n_sum_a = '0;
            n_sum_b = '0;
            n_cnt   = '0;
            n_level = (av_a > av_b) ? LEVEL_W'(av_a - av_b) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_cnt   <= '0;
            r_level <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
                r_cnt   <= n_cnt;
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.switch_level <= i_switch_level;
            r_data.drive_high   <= (pair_sum > i_drive_thr) ? 1'b0 : 1'b1;
            r_data.level        <= n_level;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[src/ahd_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_window
// max and min tracking of the held level over a window, second stage
// ----------------------------------------------------------------------------
module ahd_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ahd_pkg::t_avg_out   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ahd_pkg::t_win_out   o_data
);
    import ahd_pkg::*;

    logic                r_valid;
    t_win_out            r_data;
    logic [LEVEL_W-1:0]  r_max, r_min, r_spread;
    logic [CNT_W-1:0]    r_cnt;

    logic [LEVEL_W-1:0]  n_max, n_min, n_spread;
    logic [LEVEL_W-1:0]  upd_max, upd_min;
    logic [CNT_W-1:0]    n_cnt, cnt_inc;
    logic                load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        upd_max  = (i_data.level > r_max) ? i_data.level : r_max;
        upd_min  = (i_data.level < r_min) ? i_data.level : r_min;
        cnt_inc  = r_cnt + 1'b1;
        n_max    = upd_max;
        n_min    = upd_min;
        n_cnt    = cnt_inc;
        n_spread = r_spread;
        // window closes: publish spread and restart tracking
        if ({1'b0, cnt_inc} >= (CNT_W+1)'(WINDOW_LEN)) begin
            n_spread = (upd_max >= upd_min) ? (upd_max - upd_min) : '0;
            n_max    = '0;
            n_min    = WIN_MIN_RST;
            n_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_max    <= '0;
            r_min    <= WIN_MIN_RST;
            r_cnt    <= '0;
            r_spread <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_max    <= n_max;
                r_min    <= n_min;
                r_cnt    <= n_cnt;
                r_spread <= n_spread;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.switch_level <= i_data.switch_level;
            r_data.drive_high   <= i_data.drive_high;
            r_data.level        <= i_data.level;
            r_data.spread       <= n_spread;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[src/ahd_hyst.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahd_hyst
// threshold widening and hysteresis flag, drives the result register
// ----------------------------------------------------------------------------
module ahd_hyst (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ahd_pkg::t_win_out           i_data,
    input  logic [ahd_pkg::LEVEL_W-1:0] i_base_high,
    input  logic [ahd_pkg::LEVEL_W-1:0] i_base_low,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ahd_pkg::t_result            o_data
);
    import ahd_pkg::*;

    logic                r_valid;
    logic                r_detect;
    t_result             r_data;

    logic [LEVEL_W:0]    thr_high;
    logic [LEVEL_W:0]    half_up_w;
    logic [LEVEL_W-1:0]  half_up, thr_low;
    logic                n_detect;
    logic                load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        // high may pass 4095, then the flag cannot set
        thr_high  = {1'b0, i_base_high} + {2'b00, i_data.spread[LEVEL_W-1:1]};
        half_up_w = ({1'b0, i_data.spread} + 1'b1) >> 1;
        half_up   = half_up_w[LEVEL_W-1:0];
        thr_low   = (i_base_low > half_up) ? (i_base_low - half_up) : '0;
        n_detect  = r_detect;
        if ({1'b0, i_data.level} >= thr_high) begin
            n_detect = 1'b1;
        end else if (i_data.level <= thr_low) begin
            n_detect = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_detect <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_detect <= n_detect;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_level   <= ~(n_detect ^ i_data.switch_level);
            r_data.detect_flag <= n_detect;
            r_data.drive_high  <= i_data.drive_high;
            r_data.level       <= i_data.level;
            r_data.spread      <= i_data.spread;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[bench/tb_adaptive_hysteresis_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_hysteresis_detector_unit
// self-checking bench for the adaptive hysteresis detector: a queue-fed
// driver offers sample pairs, a bit-accurate predictor follows every
// accepted request, and a monitor compares each result field by field
// ----------------------------------------------------------------------------
module tb_adaptive_hysteresis_detector_unit;

    import ahd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RST_CYCLES    = 10;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 32;
    localparam int MAX_REPORTS   = 10;
    // index outside the register map, the block must ignore it
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [11:0] sample_a, [23:12] sample_b, [24] switch_level, rest zero
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [0] out_level, [1] detect_flag, [2] drive_high, [14:3] level,
    // [26:15] spread, rest zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;

    adaptive_hysteresis_detector_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: register copies and the detector's own state
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] cfg_base_high;
    logic [LEVEL_W-1:0] cfg_base_low;
    logic [THR_W-1:0]   cfg_drive_thr;

    logic [SUM_W-1:0]   acc_a;
    logic [SUM_W-1:0]   acc_b;
    logic [CNT_W-1:0]   acc_cnt;
    logic [LEVEL_W-1:0] held_level;
    logic [LEVEL_W-1:0] win_hi;
    logic [LEVEL_W-1:0] win_lo;
    logic [CNT_W-1:0]   win_cnt;
    logic [LEVEL_W-1:0] spread_q;
    logic               detect_q;
    logic               drive_q;

    logic [IN_TDATA_W-1:0] pending_requests[$];
    t_result               expected_results[$];

    // stimulus shaping and bookkeeping
    bit  sender_no_idle = 1'b0;
    bit  receiver_no_idle = 1'b0;
    bit  hold_go = 1'b0;
    int  hold_left = 0;
    int  shape_delta = 0;
    int  shape_cnt = 0;
    int  cycle_cnt = 0;
    int  mismatches = 0;
    int  n_requests = 0;
    int  n_results = 0;
    int  n_detect = 0;
    int  n_drive_low = 0;
    int  n_cfg_writes = 0;
    int  n_phases = 0;
    int  n_stalls = 0;

    task automatic reset_detector_model();
        cfg_base_high = BASE_HIGH_RST;
        cfg_base_low  = BASE_LOW_RST;
        cfg_drive_thr = DRIVE_THR_RST;
        acc_a      = '0;
        acc_b      = '0;
        acc_cnt    = '0;
        held_level = '0;
        win_hi     = '0;
        win_lo     = WIN_MIN_RST;
        win_cnt    = '0;
        spread_q   = '0;
        detect_q   = 1'b0;
        drive_q    = 1'b0;
    endtask

    // one acquisition through averaging, spread window and hysteresis
    task automatic detector_step(input logic [IN_TDATA_W-1:0] req, output t_result res);
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic                sw;
        logic [SAMPLE_W:0]   pair_sum;
        logic [SUM_W-1:0]    avg_a;
        logic [SUM_W-1:0]    avg_b;
        logic [LEVEL_W+1:0]  thr_high;
        logic [LEVEL_W:0]    half_up;
        logic [LEVEL_W:0]    thr_low;
        a  = req[11:0];
        b  = req[23:12];
        sw = req[24];

        pair_sum = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
        drive_q  = (pair_sum > cfg_drive_thr) ? 1'b0 : 1'b1;

        acc_a   = acc_a + SUM_W'(a);
        acc_b   = acc_b + SUM_W'(b);
        acc_cnt = acc_cnt + 1'b1;
        if (acc_cnt == 0 || acc_cnt >= AVG_COUNT) begin
            avg_a = acc_a / SUM_W'(AVG_COUNT);
            avg_b = acc_b / SUM_W'(AVG_COUNT);
            // difference of the averages, clamped at zero
            held_level = (avg_a > avg_b) ? LEVEL_W'(avg_a - avg_b) : '0;
            acc_a   = '0;
            acc_b   = '0;
            acc_cnt = '0;
        end

        if (held_level > win_hi) win_hi = held_level;
        if (held_level < win_lo) win_lo = held_level;
        win_cnt = win_cnt + 1'b1;
        if (win_cnt >= WINDOW_LEN) begin
            spread_q = (win_hi >= win_lo) ? (win_hi - win_lo) : '0;
            win_hi   = '0;
            win_lo   = WIN_MIN_RST;
            win_cnt  = '0;
        end

        // upper threshold kept wide so it can pass 4095
        thr_high = (LEVEL_W+2)'(cfg_base_high) + (LEVEL_W+2)'(spread_q >> 1);
        half_up  = ({1'b0, spread_q} + 1'b1) >> 1;
        thr_low  = (cfg_base_low > half_up) ? (cfg_base_low - half_up) : '0;
        if (held_level >= thr_high)
            detect_q = 1'b1;
        else if (held_level <= thr_low)
            detect_q = 1'b0;

        res.out_level   = ~(sw ^ detect_q);
        res.detect_flag = detect_q;
        res.drive_high  = drive_q;
        res.level       = held_level;
        res.spread      = spread_q;
    endtask

    // ------------------------------------------------------------------
    // request driver: one nonblocking update of valid and data per edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result res;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                detector_step(s_axis_tdata, res);
                expected_results.push_back(res);
                n_requests++;
            end
            // a request still waiting for ready keeps its data
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 &&
                    (sender_no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_axis_tdata  <= pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go) begin
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= receiver_no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: field-by-field compare against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && !m_axis_tready) n_stalls++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_level   = m_axis_tdata[0];
            got.detect_flag = m_axis_tdata[1];
            got.drive_high  = m_axis_tdata[2];
            got.level       = m_axis_tdata[14:3];
            got.spread      = m_axis_tdata[26:15];
            n_results++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result, tdata=%h", $realtime, m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (want.detect_flag) n_detect++;
                if (!want.drive_high) n_drive_low++;
                if (got.out_level !== want.out_level ||
                    got.detect_flag !== want.detect_flag ||
                    got.drive_high !== want.drive_high ||
                    got.level !== want.level ||
                    got.spread !== want.spread) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] result %0d: exp out=%0d det=%0d drv=%0d lvl=%0d spr=%0d",
                                 $realtime, n_results, want.out_level, want.detect_flag,
                                 want.drive_high, want.level, want.spread,
                                 " | got out=%0d det=%0d drv=%0d lvl=%0d spr=%0d",
                                 got.out_level, got.detect_flag, got.drive_high,
                                 got.level, got.spread);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("tb_adaptive_hysteresis_detector_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [IN_TDATA_W-1:0] pack_request(int a, int b, bit sw);
        return {7'b0, sw, b[11:0], a[11:0]};
    endfunction

    function automatic int clamp_sample(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // random request: mostly level steps held over an averaging block so
    // the difference lands around the thresholds, the rest noise, extreme
    // codes and sums close to the drive threshold
    task automatic push_random_request();
        int pick;
        int a;
        int b;
        int lim;
        pick = $urandom_range(0, 99);
        lim  = (cfg_base_high * 2 + 60 > 4095) ? 4095 : cfg_base_high * 2 + 60;
        if (shape_cnt % AVG_COUNT == 0) shape_delta = $urandom_range(0, lim);
        shape_cnt++;
        if (pick < 55) begin
            b = $urandom_range(0, 3000);
            a = clamp_sample(b + shape_delta + $urandom_range(0, 6) - 3);
        end else if (pick < 75) begin
            a = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
        end else if (pick < 85) begin
            a = $urandom_range(0, 1) ? 4095 : 0;
            b = $urandom_range(0, 1) ? 4095 : 0;
        end else begin
            a = $urandom_range(0, 4095);
            b = clamp_sample(int'(cfg_drive_thr) - a + $urandom_range(0, 2) - 1);
        end
        pending_requests.push_back(pack_request(a, b, 1'($urandom_range(0, 1))));
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_BASE_HIGH: cfg_base_high = value[LEVEL_W-1:0];
            REG_BASE_LOW:  cfg_base_low  = value[LEVEL_W-1:0];
            REG_DRIVE_THR: cfg_drive_thr = value[THR_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // wait until every request is in and every result is out, then let
    // the pipe settle before anything else touches the registers
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || s_axis_tvalid ||
               expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_phases++;
    endtask

    task automatic run_random(int count);
        repeat (count) push_random_request();
        wait_drained();
    endtask

    task automatic push_block(int a, int b, int count);
        repeat (count)
            pending_requests.push_back(pack_request(a, b, 1'($urandom_range(0, 1))));
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        reset_detector_model();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, clamp to zero, threshold edges, drive edge
        push_block(0, 0, AVG_COUNT);
        push_block(4095, 0, AVG_COUNT);
        push_block(0, 4095, AVG_COUNT);
        push_block(40, 0, AVG_COUNT);
        push_block(21, 0, AVG_COUNT);
        pending_requests.push_back(pack_request(2200, 2200, 1'b0));
        pending_requests.push_back(pack_request(2200, 2201, 1'b1));
        pending_requests.push_back(pack_request(4095, 4095, 1'b1));
        wait_drained();

        // upper threshold at its top (bit 12 of the write masked off), release
        // at zero, every request with a nonzero sample sum gets the short pulse
        write_register(REG_BASE_HIGH, 13'h1FFF);
        write_register(REG_BASE_LOW, '0);
        write_register(REG_DRIVE_THR, '0);
        run_random(80);

        // set at zero, release at the top, long pulse always; the write
        // to the unmapped index must leave everything alone
        write_register(REG_BASE_HIGH, '0);
        write_register(REG_BASE_LOW, 13'd4095);
        write_register(REG_DRIVE_THR, 13'h1FFF);
        write_register(REG_UNMAPPED, 13'h0ABC);
        run_random(80);

        // defaults again with both sides running flat out
        write_register(REG_BASE_HIGH, CFG_W'(BASE_HIGH_RST));
        write_register(REG_BASE_LOW, CFG_W'(BASE_LOW_RST));
        write_register(REG_DRIVE_THR, DRIVE_THR_RST);
        sender_no_idle   <= 1'b1;
        receiver_no_idle <= 1'b1;
        run_random(150);

        // long receiver hold-off while the sender keeps pushing
        write_register(REG_BASE_HIGH, CFG_W'($urandom_range(0, 300)));
        repeat (100) push_random_request();
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        wait_drained();
        sender_no_idle   <= 1'b0;
        receiver_no_idle <= 1'b0;

        // random settings, mostly narrow thresholds, now and then wide
        repeat (4) begin
            write_register(REG_BASE_HIGH, CFG_W'(($urandom_range(0, 4) == 0) ?
                           $urandom_range(0, 4095) : $urandom_range(0, 300)));
            write_register(REG_BASE_LOW, CFG_W'(($urandom_range(0, 4) == 0) ?
                           $urandom_range(0, 4095) : $urandom_range(0, 150)));
            write_register(REG_DRIVE_THR, CFG_W'($urandom_range(0, 8190)));
            run_random(85);
        end

        $display("covered %0d requests and %0d results over %0d phases, %0d register writes",
                 n_requests, n_results, n_phases, n_cfg_writes);
        $display("detect high in %0d results, short pulse in %0d, %0d stalled result cycles",
                 n_detect, n_drive_low, n_stalls);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_adaptive_hysteresis_detector_unit OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("tb_adaptive_hysteresis_detector_unit NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
src/ahd_pkg.sv
src/ahd_avg.sv
src/ahd_window.sv
src/ahd_hyst.sv
src/adaptive_hysteresis_detector_unit.sv
bench/tb_adaptive_hysteresis_detector_unit.sv
